[hdl/lgs_pkg.sv]
// Shared types, constants and helpers for the life grid generation step block.
`default_nettype none

package lgs_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int CFG_DIM_W  = 7;
  localparam int COORD_W    = 6;
  localparam int OPCODE_W   = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_DIM_W-1:0] RESET_COLUMNS = 7'd60;
  localparam logic [CFG_DIM_W-1:0] RESET_ROWS    = 7'd40;
  localparam int MIN_DIM = 3;

  localparam int BIRTH_COUNT  = 3;
  localparam int SURVIVE_LOW  = 2;
  localparam int SURVIVE_HIGH = 3;

  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd2;

  localparam logic CFG_IDX_COLUMNS = 1'b0;
  localparam logic CFG_IDX_ROWS    = 1'b1;

  // Control handed to every column cell of the window.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  // Clamp a raw dimension register into MIN_DIM..maxv.
  function automatic int clamp_dim(logic [CFG_DIM_W-1:0] v, int maxv);
    if (int'(v) < MIN_DIM) return MIN_DIM;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

endpackage

`default_nettype wire

[hdl/lgs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/lgs_cell.sv]
// One column cell: holds its three window bits and applies the B3/S23 rule.
`default_nettype none

module lgs_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lgs_pkg::cell_ctrl_t ctrl,
  input  wire logic                bit_in,
  input  wire logic                active,
  input  wire logic [2:0]          left_nb,
  input  wire logic [2:0]          right_nb,
  output      logic [2:0]          nb_out,
  output      logic                next_bit
);

  logic       w0_r, w1_r, w2_r;
  logic [3:0] count;
  logic       rule_bit;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      w0_r <= 1'b0;
      w1_r <= 1'b0;
      w2_r <= 1'b0;
    end else if (ctrl.shift) begin
      w0_r <= w1_r;
      w1_r <= w2_r;
      w2_r <= bit_in;
    end
  end

  // Columns beyond the active area look dead to their neighbours
  assign nb_out = active ? {w2_r, w1_r, w0_r} : 3'b000;

  always_comb begin
    count = 4'(left_nb[0]) + 4'(left_nb[1]) + 4'(left_nb[2])
          + 4'(right_nb[0]) + 4'(right_nb[1]) + 4'(right_nb[2])
          + 4'(w0_r) + 4'(w2_r);
    if (w1_r) begin
      rule_bit = (int'(count) >= lgs_pkg::SURVIVE_LOW) &&
                 (int'(count) <= lgs_pkg::SURVIVE_HIGH);
    end else begin
      rule_bit = (int'(count) == lgs_pkg::BIRTH_COUNT);
    end
    // Hold the old value outside the active area
    next_bit = active ? rule_bit : w1_r;
  end

endmodule

`default_nettype wire

[hdl/life_grid_generation_step.sv]
// Top level of the life grid generation step block.
// Holds a cell grid of MAX_ROWS x MAX_COLUMNS in a RAM with one valid bit per row
// (a row never written reads as dead, so no clearing pass follows reset). Each input
// beat is one operation: a cell write or read is worked on in the access state (row
// read-modify-write or bit select on the fetched row) and then in the done state that
// gives the result beat; an access outside the active area or an unused opcode goes
// straight to the done state; a generation step is a sweep that reads one row
// per cycle from the single RAM read port through a row of MAX_COLUMNS column cells
// holding a three-row window, then writes the next generation of each row back.
// One operation is worked on at a time; a finished result waits in the output
// register and the next beat is taken once the result is moved there.
`default_nettype none

module life_grid_generation_step #(
  parameter int MAX_COLUMNS = lgs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = lgs_pkg::DEF_MAX_ROWS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // opcode[1:0], column[7:2], row[13:8], cell_value[14], zero[15]
  input  wire logic [lgs_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // cell_alive[0], address_error[1], zero[7:2]
  output      logic [lgs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_addr,
  input  wire logic [lgs_pkg::CFG_DIM_W-1:0]    cfg_wdata
);

  localparam int CA_W = $clog2(MAX_COLUMNS);
  localparam int RA_W = $clog2(MAX_ROWS);
  localparam int CC_W = $clog2(MAX_COLUMNS + 1);
  localparam int RC_W = $clog2(MAX_ROWS + 1);
  localparam int T_W  = $clog2(MAX_ROWS + 3);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [T_W-1:0] t_r, t_nxt;
  logic [CC_W-1:0] cols_r;
  logic [RC_W-1:0] rows_r;

  logic [lgs_pkg::OPCODE_W-1:0] in_op;
  logic [lgs_pkg::COORD_W-1:0]  in_col, in_row;
  logic                         in_val;
  logic                         in_fire, in_access, in_err;

  logic            acc_wr_r, acc_val_r;
  logic [CA_W-1:0] acc_col_r;
  logic [RA_W-1:0] acc_row_r;
  logic            res_alive_r, res_err_r;
  logic            out_tvalid_r, out_alive_r, out_err_r;
  logic            out_free;

  logic [MAX_ROWS-1:0]    valid_r;
  logic                   rvalid_r;
  logic                   ram_we;
  logic [RA_W-1:0]        ram_waddr, ram_raddr;
  logic [MAX_COLUMNS-1:0] ram_wdata, ram_rdata, row_in, acc_row_data;

  logic [T_W-1:0]   rows_t;
  logic             step_shift, step_write, step_last;
  lgs_pkg::cell_ctrl_t cell_ctrl;
  logic [MAX_COLUMNS-1:0] col_active, next_row, cell_bit_in;
  logic [2:0] nb [MAX_COLUMNS];

  assign in_op  = in_tdata[1:0];
  assign in_col = in_tdata[7:2];
  assign in_row = in_tdata[13:8];
  assign in_val = in_tdata[14];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_access = (in_op == lgs_pkg::OP_WRITE) || (in_op == lgs_pkg::OP_READ);
  assign in_err    = in_access &&
                     ((int'(in_col) >= int'(cols_r)) || (int'(in_row) >= int'(rows_r)));

  assign out_free = !out_tvalid_r || out_tready;
  assign rows_t   = T_W'(rows_r);

  // Sweep timing: read row t, shift row t-1 in at t, write row t-3 at t
  assign step_shift = (state_r == ST_STEP) && (t_r >= T_W'(1)) && (t_r <= rows_t + T_W'(1));
  assign step_last  = (t_r == rows_t + T_W'(1));
  assign step_write = (state_r == ST_STEP) && (t_r >= T_W'(3));

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CC_W'(lgs_pkg::clamp_dim(lgs_pkg::RESET_COLUMNS, MAX_COLUMNS));
      rows_r <= RC_W'(lgs_pkg::clamp_dim(lgs_pkg::RESET_ROWS, MAX_ROWS));
    end else if (cfg_we) begin
      if (cfg_addr == lgs_pkg::CFG_IDX_COLUMNS) begin
        cols_r <= CC_W'(lgs_pkg::clamp_dim(cfg_wdata, MAX_COLUMNS));
      end
      if (cfg_addr == lgs_pkg::CFG_IDX_ROWS) begin
        rows_r <= RC_W'(lgs_pkg::clamp_dim(cfg_wdata, MAX_ROWS));
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    case (state_r)
      ST_IDLE: begin
        t_nxt = '0;
        if (in_fire) begin
          if (in_op == lgs_pkg::OP_STEP) begin
            state_nxt = ST_STEP;
          end else if (in_access && !in_err) begin
            state_nxt = ST_ACC;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ACC: begin
        state_nxt = ST_DONE;
      end
      ST_STEP: begin
        t_nxt = t_r + T_W'(1);
        if (t_r == rows_t + T_W'(2)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_r     <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
    end
  end

  // Operation and result hold
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_wr_r    <= (in_op == lgs_pkg::OP_WRITE);
      acc_val_r   <= in_val;
      acc_col_r   <= CA_W'(in_col);
      acc_row_r   <= RA_W'(in_row);
      res_alive_r <= 1'b0;
      res_err_r   <= in_err;
    end else if (state_r == ST_ACC) begin
      res_alive_r <= acc_wr_r ? 1'b0 : row_in[acc_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_alive_r <= res_alive_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(lgs_pkg::OUT_DATA_W - 2){1'b0}}, out_err_r, out_alive_r};

  // Grid store; rows never written read as dead through their valid bit
  always_comb begin
    acc_row_data            = row_in;
    acc_row_data[acc_col_r] = acc_val_r;
  end

  always_comb begin
    ram_raddr = (state_r == ST_IDLE) ? RA_W'(in_row) : RA_W'(t_r);
    ram_we    = step_write || (state_r == ST_ACC && acc_wr_r);
    ram_waddr = (state_r == ST_STEP) ? RA_W'(t_r - T_W'(3)) : acc_row_r;
    ram_wdata = (state_r == ST_STEP) ? next_row : acc_row_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rvalid_r <= valid_r[ram_raddr];
  end

  assign row_in = rvalid_r ? ram_rdata : '0;

  lgs_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Column cells
  assign cell_ctrl.clear = in_fire && (in_op == lgs_pkg::OP_STEP);
  assign cell_ctrl.shift = step_shift;
  assign cell_bit_in     = step_last ? '0 : row_in;

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
    logic [2:0] left_nb, right_nb;

    assign col_active[c] = (c < int'(cols_r));

    if (c == 0) begin : g_left_edge
      assign left_nb = 3'b000;
    end else begin : g_left
      assign left_nb = nb[c-1];
    end

    if (c == MAX_COLUMNS - 1) begin : g_right_edge
      assign right_nb = 3'b000;
    end else begin : g_right
      assign right_nb = nb[c+1];
    end

    lgs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .bit_in   (cell_bit_in[c]),
      .active   (col_active[c]),
      .left_nb  (left_nb),
      .right_nb (right_nb),
      .nb_out   (nb[c]),
      .next_bit (next_row[c])
    );
  end

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("accepted beat did not start an operation");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_ACC || state_r == ST_STEP))
    else $error("grid written outside an access or sweep");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> t_r <= rows_t + T_W'(2))
    else $error("sweep counter ran past the last row");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised without a finished operation");

endmodule

`default_nettype wire
